### rtl/spsh_pkg.sv
// Shared types and constants for the procedural sphere pixel shader.
// Used by every module of the block; depends on nothing.
package spsh_pkg;

  // Number of register stages from the input beat to the output registers.
  localparam int NUM_STAGES = 11;

  // Scene geometry.
  localparam int CENTRE_X = 36;
  localparam int CENTRE_Y = 18;
  localparam int SPHERE_RADIUS_SQ = 200;

  // One enable bit per pipeline stage, bit k loads stage k.
  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  // Which part of the scene a pixel falls into.
  typedef logic [1:0] region_t;
  localparam region_t REGION_SPHERE = 2'd0;
  localparam region_t REGION_FLOOR  = 2'd1;
  localparam region_t REGION_SKY    = 2'd2;

  // Per-pixel geometry handed from the front end to the shading paths.
  typedef struct packed {
    logic signed [7:0]  u;     // x minus centre column
    logic signed [6:0]  v;     // centre row minus y
    logic signed [12:0] uv;    // u times v
    logic        [13:0] h;     // squared distance to the centre
    logic        [12:0] t;     // sphere scale term, valid inside the sphere
    logic signed [15:0] fc;    // floor lighting term
    logic        [7:0]  red0;  // floor base red
  } geom_t;

endpackage

### rtl/spsh_geom.sv
// Front end of the shader pipeline: centre offsets, squared distance, region
// choice and sky colors, stages 0 and 1. Depends on spsh_pkg.
module spsh_geom (
  input  logic                clk,
  input  spsh_pkg::stage_vec_t en,
  input  logic [6:0]          pix_x,
  input  logic [5:0]          pix_y,
  output spsh_pkg::geom_t     geo,
  output spsh_pkg::region_t   region,
  output logic [7:0]          sky_red,
  output logic [7:0]          sky_blue
);
  import spsh_pkg::*;

  logic signed [7:0]  u_c;
  logic signed [6:0]  v_c;
  logic signed [15:0] uu_full;
  logic signed [13:0] vv_full;
  logic signed [14:0] uv_full;
  logic        [8:0]  sky_c;
  logic        [9:0]  sky_r_sum;
  logic        [9:0]  sky_b_sum;

  logic signed [7:0]  s0_u;
  logic signed [6:0]  s0_v;
  logic        [13:0] s0_uu;
  logic        [10:0] s0_vv;
  logic signed [12:0] s0_uv;
  logic        [7:0]  s0_sky_red;
  logic        [7:0]  s0_sky_blue;

  logic        [13:0] h_c;
  logic        [12:0] t_c;
  logic        [14:0] fp_c;
  logic signed [16:0] fc_wide;
  logic signed [8:0]  red0_wide;
  region_t            region_c;

  // Stage 0: offsets from the centre and their products, sky gradient.
  always_comb begin
    u_c       = $signed({1'b0, pix_x}) - 8'(CENTRE_X);
    v_c       = 7'(CENTRE_Y) - $signed({1'b0, pix_y});
    uu_full   = u_c * u_c;
    vv_full   = v_c * v_c;
    uv_full   = u_c * v_c;
    sky_c     = {2'b00, pix_x} + {1'b0, pix_y, 2'b00};
    sky_r_sum = 10'd132 + {1'b0, sky_c};
    sky_b_sum = 10'd192 + {1'b0, sky_c};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_u        <= u_c;
      s0_v        <= v_c;
      s0_uu       <= uu_full[13:0];
      s0_vv       <= vv_full[10:0];
      s0_uv       <= uv_full[12:0];
      s0_sky_red  <= (sky_r_sum > 10'd255) ? 8'hFF : sky_r_sum[7:0];
      s0_sky_blue <= (sky_b_sum > 10'd255) ? 8'hFF : sky_b_sum[7:0];
    end
  end

  // Stage 1: squared distance, region, sphere scale and floor terms.
  always_comb begin
    h_c       = s0_uu + {3'b000, s0_vv};
    t_c       = 13'd5000 + {2'b00, h_c[7:0], 3'b000};
    fp_c      = {1'b0, h_c} + {1'b0, s0_vv, 3'b000};
    fc_wide   = -(17'sd240 * 17'(s0_v)) - $signed({2'b00, fp_c});
    red0_wide = 9'sd150 + $signed({s0_v, 1'b0});
    if (h_c < 14'(SPHERE_RADIUS_SQ)) begin
      region_c = REGION_SPHERE;
    end else if (s0_v[6]) begin
      region_c = REGION_FLOOR;
    end else begin
      region_c = REGION_SKY;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      geo.u    <= s0_u;
      geo.v    <= s0_v;
      geo.uv   <= s0_uv;
      geo.h    <= h_c;
      geo.t    <= t_c;
      geo.fc   <= fc_wide[15:0];
      geo.red0 <= red0_wide[7:0];
      region   <= region_c;
      sky_red  <= s0_sky_red;
      sky_blue <= s0_sky_blue;
    end
  end

endmodule

### rtl/spsh_sphere.sv
// Sphere shading path: highlight, diffuse scale and specular term, stages 2
// to 8, with the result held until the floor path catches up. Uses spsh_pkg.
module spsh_sphere (
  input  logic                clk,
  input  spsh_pkg::stage_vec_t en,
  input  spsh_pkg::geom_t     geo,
  output logic [7:0]          sph_red,
  output logic [7:0]          sph_blue
);
  import spsh_pkg::*;

  logic signed [21:0] tu_full;
  logic signed [20:0] tv_full;
  logic signed [17:0] s2_tu;
  logic signed [17:0] s2_tv;

  logic signed [10:0] p_c;
  logic signed [10:0] q_c;
  logic signed [11:0] s_c;
  logic signed [12:0] wsum_c;
  logic signed [6:0]  w_c;
  logic signed [11:0] pq_c;
  logic signed [12:0] os_wide;
  logic        [5:0]  s3_ws;
  logic        [7:0]  s3_hi;
  logic        [11:0] s3_os;

  logic        [10:0] s4_rs0;
  logic        [11:0] s4_os;
  logic        [7:0]  s4_hi;

  logic        [22:0] rprod_c;
  logic        [21:0] bprod_c;
  logic        [9:0]  s5_red;
  logic        [8:0]  s5_blue;

  logic        [7:0]  s6_red;
  logic        [7:0]  s6_blue;
  logic        [7:0]  s7_red;
  logic        [7:0]  s7_blue;

  // Stage 2: scale the offsets by the sphere term.
  always_comb begin
    tu_full = $signed({1'b0, geo.t}) * geo.u;
    tv_full = $signed({1'b0, geo.t}) * geo.v;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_tu <= tu_full[17:0];
      s2_tv <= tv_full[17:0];
    end
  end

  // Stage 3: floored shifts, highlight weight, specular term and light factor.
  always_comb begin
    p_c     = s2_tu[17:7];
    q_c     = s2_tv[17:7];
    s_c     = {q_c, 1'b0};
    wsum_c  = 13'sd1000 + 13'(p_c) - 13'(s_c);
    w_c     = 7'($signed(wsum_c[12:7])) + 7'sd8;
    pq_c    = 12'(p_c) + 12'(q_c);
    os_wide = 13'sd2200 + 13'(s_c);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ws <= (w_c > 7'sd0) ? w_c[5:0] : 6'd0;
      s3_hi <= (pq_c > 12'sd0) ? pq_c[10:3] : 8'd0;
      s3_os <= os_wide[11:0];
    end
  end

  // Stage 4: base red with the squared highlight.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_rs0 <= 11'd420 + 11'(s3_ws) * 11'(s3_ws);
      s4_os  <= s3_os;
      s4_hi  <= s3_hi;
    end
  end

  // Stage 5: apply the light factor, then add the specular term.
  always_comb begin
    rprod_c = 23'(s4_rs0) * 23'(s4_os);
    bprod_c = 22'd520 * 22'(s4_os);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_red  <= rprod_c[22:13] + 10'(s4_hi);
      s5_blue <= bprod_c[21:13] + 9'(s4_hi);
    end
  end

  // Stage 6 clamps at full scale; stages 7 and 8 hold the result in step.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_red  <= (s5_red > 10'd255) ? 8'hFF : s5_red[7:0];
      s6_blue <= (s5_blue > 9'd255) ? 8'hFF : s5_blue[7:0];
    end
    if (en[7]) begin
      s7_red  <= s6_red;
      s7_blue <= s6_blue;
    end
    if (en[8]) begin
      sph_red  <= s7_red;
      sph_blue <= s7_blue;
    end
  end

endmodule

### rtl/spsh_floor.sv
// Floor shading path: light falloff with its divisions by ten and a hundred,
// shadow term and clamp, stages 2 to 8. Uses spsh_pkg.
module spsh_floor (
  input  logic                clk,
  input  spsh_pkg::stage_vec_t en,
  input  spsh_pkg::geom_t     geo,
  output logic [7:0]          flr_red,
  output logic [7:0]          flr_blue
);
  import spsh_pkg::*;

  // Reciprocals: 6/10 scaled by 2^19, and 1/100 scaled by 2^26 (rounded down).
  localparam logic [32:0] RECIP_SIX_TENTHS = 33'd314574;
  localparam logic [45:0] RECIP_HUNDRED    = 46'd671088;

  logic        [32:0] o6_full;
  logic signed [16:0] r_c;
  logic signed [18:0] d_c;
  logic               s2_lit;
  logic        [13:0] s2_c;
  logic        [12:0] s2_o6;
  logic        [16:0] s2_dpos;
  logic        [7:0]  s2_red0;

  logic signed [13:0] m_c;
  logic signed [28:0] fo_full;
  logic signed [26:0] s3_fo;
  logic               s3_lit;
  logic        [16:0] s3_dpos;
  logic        [7:0]  s3_red0;

  logic        [25:0] mag_c;
  logic        [45:0] est_full;
  logic        [25:0] s4_mag;
  logic        [19:0] s4_q0;
  logic               s4_neg;
  logic               s4_lit;
  logic        [16:0] s4_dpos;
  logic        [7:0]  s4_red0;

  logic        [26:0] rem_c;
  logic        [19:0] s5_q;
  logic               s5_neg;
  logic               s5_lit;
  logic        [16:0] s5_dpos;
  logic        [7:0]  s5_red0;

  logic signed [20:0] qs_c;
  logic signed [20:0] s6_fo2;
  logic               s6_lit;
  logic        [16:0] s6_dpos;
  logic        [7:0]  s6_red0;

  logic signed [29:0] rprod_c;
  logic signed [29:0] bprod_c;
  logic signed [19:0] s7_rf;
  logic signed [19:0] s7_bf;
  logic        [16:0] s7_dpos;

  logic signed [20:0] red_sum_c;

  // Stage 2: six tenths of the light term, and the shadow term.
  always_comb begin
    o6_full = 33'(geo.fc[13:0]) * RECIP_SIX_TENTHS;
    r_c     = 17'(geo.fc) + 17'(geo.uv);
    d_c     = 19'sd3200 - $signed(19'(geo.h)) - $signed({r_c, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_lit  <= geo.fc > 16'sd1200;
      s2_c    <= geo.fc[13:0];
      s2_o6   <= o6_full[31:19];
      s2_dpos <= (d_c > 19'sd0) ? d_c[16:0] : 17'd0;
      s2_red0 <= geo.red0;
    end
  end

  // Stage 3: light term times its complement.
  always_comb begin
    m_c     = 14'sd1500 - $signed({1'b0, s2_o6});
    fo_full = $signed({1'b0, s2_c}) * m_c;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_fo   <= fo_full[26:0];
      s3_lit  <= s2_lit;
      s3_dpos <= s2_dpos;
      s3_red0 <= s2_red0;
    end
  end

  // Stage 4: magnitude and quotient estimate for the division by a hundred.
  // The estimate is the true quotient or one below it.
  always_comb begin
    mag_c    = s3_fo[26] ? 26'(-s3_fo) : s3_fo[25:0];
    est_full = 46'(mag_c) * RECIP_HUNDRED;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_mag  <= mag_c;
      s4_q0   <= est_full[45:26];
      s4_neg  <= s3_fo[26];
      s4_lit  <= s3_lit;
      s4_dpos <= s3_dpos;
      s4_red0 <= s3_red0;
    end
  end

  // Stage 5: correct the estimate by one where the remainder overflows.
  always_comb begin
    rem_c = 27'(s4_mag) - 27'(s4_q0) * 27'd100;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_q    <= s4_q0 + 20'(rem_c >= 27'd100);
      s5_neg  <= s4_neg;
      s5_lit  <= s4_lit;
      s5_dpos <= s4_dpos;
      s5_red0 <= s4_red0;
    end
  end

  // Stage 6: restore the sign, so the quotient truncates toward zero.
  always_comb begin
    qs_c = s5_neg ? -$signed({1'b0, s5_q}) : $signed({1'b0, s5_q});
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_fo2  <= qs_c - 21'sd8360;
      s6_lit  <= s5_lit;
      s6_dpos <= s5_dpos;
      s6_red0 <= s5_red0;
    end
  end

  // Stage 7: scale the base colors where the floor is lit.
  always_comb begin
    rprod_c = $signed({22'd0, s6_red0}) * 30'(s6_fo2);
    bprod_c = 30'sd50 * 30'(s6_fo2);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (s6_lit) begin
        s7_rf <= rprod_c[29:10];
        s7_bf <= bprod_c[29:10];
      end else begin
        s7_rf <= $signed({12'd0, s6_red0});
        s7_bf <= 20'sd50;
      end
      s7_dpos <= s6_dpos;
    end
  end

  // Stage 8: add the shadow term to red and clamp both channels.
  always_comb begin
    red_sum_c = 21'(s7_rf) + $signed({4'd0, s7_dpos});
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (red_sum_c < 21'sd0) begin
        flr_red <= 8'd0;
      end else if (red_sum_c > 21'sd255) begin
        flr_red <= 8'hFF;
      end else begin
        flr_red <= red_sum_c[7:0];
      end
      if (s7_bf < 20'sd0) begin
        flr_blue <= 8'd0;
      end else if (s7_bf > 20'sd255) begin
        flr_blue <= 8'hFF;
      end else begin
        flr_blue <= s7_bf[7:0];
      end
    end
  end

endmodule

### rtl/spsh_mix.sv
// Back end of the shader pipeline: carries the region and sky colors, picks
// the branch, and derives green, stages 2 to 10. Uses spsh_pkg.
module spsh_mix (
  input  logic                clk,
  input  spsh_pkg::stage_vec_t en,
  input  spsh_pkg::region_t   region,
  input  logic [7:0]          sky_red,
  input  logic [7:0]          sky_blue,
  input  logic [7:0]          sph_red,
  input  logic [7:0]          sph_blue,
  input  logic [7:0]          flr_red,
  input  logic [7:0]          flr_blue,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);
  import spsh_pkg::*;

  // Stages 2 to 8 of the carry line.
  localparam int CARRY_DEPTH = 7;
  localparam logic [27:0] RECIP_TENTH = 28'd52429;

  typedef struct packed {
    region_t    region;
    logic [7:0] sky_red;
    logic [7:0] sky_blue;
  } carry_t;

  carry_t      carry [CARRY_DEPTH];
  carry_t      last_c;
  logic [7:0]  red_c;
  logic [7:0]  blue_c;
  logic [7:0]  s9_red;
  logic [7:0]  s9_blue;
  logic [11:0] s9_sum;
  logic [27:0] gfull_c;

  // Carry line that keeps the region in step with the shading paths.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      carry[0] <= '{region: region, sky_red: sky_red, sky_blue: sky_blue};
    end
    for (int k = 1; k < CARRY_DEPTH; k++) begin
      if (en[k+2]) begin
        carry[k] <= carry[k-1];
      end
    end
  end

  // Stage 9: branch selection and the weighted sum for green.
  always_comb begin
    last_c = carry[CARRY_DEPTH-1];
    case (last_c.region)
      REGION_SPHERE: begin
        red_c  = sph_red;
        blue_c = sph_blue;
      end
      REGION_FLOOR: begin
        red_c  = flr_red;
        blue_c = flr_blue;
      end
      default: begin
        red_c  = last_c.sky_red;
        blue_c = last_c.sky_blue;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_red  <= red_c;
      s9_blue <= blue_c;
      s9_sum  <= 12'(red_c) * 12'd7 + 12'(blue_c) * 12'd3;
    end
  end

  // Stage 10: divide by ten through the reciprocal, exact for this range.
  always_comb begin
    gfull_c = 28'(s9_sum) * RECIP_TENTH;
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      red   <= s9_red;
      green <= gfull_c[26:19];
      blue  <= s9_blue;
    end
  end

endmodule

### rtl/procedural_sphere_pixel_shader_top.sv
// Top level of the procedural sphere pixel shader: valid tracking, stall
// handling and the four datapath modules. Depends on spsh_pkg.

// One pixel coordinate beat goes in and one RGB beat comes out for each
// pixel, at a sustained rate of one pixel per clock cycle while out_stall
// is low. An accepted input beat passes to the output beat through the
// eleven register stages of the datapath: two for the geometry, seven for
// the parallel sphere and floor shading paths (the division by a hundred on
// the floor side takes three of them), and two for branch selection and
// green. Each stage holds its own valid bit and loads whenever it is empty
// or the stage after it moves, so gaps in the stream are squeezed out under
// a downstream stall and in_stall rises only when all eleven stages are full.
module procedural_sphere_pixel_shader_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [6:0] pix_x,
  input  logic [5:0] pix_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import spsh_pkg::*;

  stage_vec_t en;
  stage_vec_t vld;
  geom_t      geo;
  region_t    region;
  logic [7:0] sky_red;
  logic [7:0] sky_blue;
  logic [7:0] sph_red;
  logic [7:0] sph_blue;
  logic [7:0] flr_red;
  logic [7:0] flr_blue;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NUM_STAGES-1];

  spsh_geom u_geom (
    .clk      (clk),
    .en       (en),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .geo      (geo),
    .region   (region),
    .sky_red  (sky_red),
    .sky_blue (sky_blue)
  );

  spsh_sphere u_sphere (
    .clk      (clk),
    .en       (en),
    .geo      (geo),
    .sph_red  (sph_red),
    .sph_blue (sph_blue)
  );

  spsh_floor u_floor (
    .clk      (clk),
    .en       (en),
    .geo      (geo),
    .flr_red  (flr_red),
    .flr_blue (flr_blue)
  );

  spsh_mix u_mix (
    .clk      (clk),
    .en       (en),
    .region   (region),
    .sky_red  (sky_red),
    .sky_blue (sky_blue),
    .sph_red  (sph_red),
    .sph_blue (sph_blue),
    .flr_red  (flr_red),
    .flr_blue (flr_blue),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

`ifndef NO_ASSERTIONS
  // The input side stalls only when no stage has a bubble left.
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst) in_stall |-> (&vld)
  ) else $error("input stalled while a pipeline stage was empty");

  // Green is a weighted mean of red and blue, so it lies between them.
  a_green_between: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> ((green <= red) || (green <= blue)) &&
                  ((green >= red) || (green >= blue))
  ) else $error("green outside the range of red and blue");

  // Reset empties the pipeline and opens the input.
  a_reset_empties: assert property (
    @(posedge clk) rst |=> !out_valid && !in_stall
  ) else $error("pipeline not empty after reset");
`endif

endmodule
